>>> sv/crank_tooth_rpm_meter_macros.svh
// assertion macros used by the rpm meter core
`ifndef CRANK_TOOTH_RPM_METER_MACROS_SVH
`define CRANK_TOOTH_RPM_METER_MACROS_SVH

// same-cycle implication, checked out of reset
`define CTRM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpm meter check failed");

// next-cycle implication, checked out of reset
`define CTRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpm meter check failed");

`endif

>>> sv/ctrm_pkg.sv
// package with shared constants and types of the crank tooth rpm meter
package ctrm_pkg;

    localparam int TIME_WIDTH_DEF  = 32;
    localparam int CFG_WIDTH       = 32;
    localparam int CFG_IDX_WIDTH   = 3;
    localparam int TOOTH_WIDTH     = 6;
    localparam int DEBOUNCE_WIDTH  = 16;
    localparam int RPM_WIDTH       = 16;
    localparam int DIVIDEND_WIDTH  = 26;
    localparam int CNT_WIDTH       = 5;

    localparam int US_PER_MINUTE   = 60000000;
    localparam int RPM_CEILING     = 60000;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_TEETH_PER_REV = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_TIMEOUT       = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEBOUNCE      = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MIN_PERIOD    = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_PERIOD    = 3'd4;

    localparam logic [TOOTH_WIDTH-1:0]    RST_TEETH_PER_REV = 6'd11;
    localparam logic [CFG_WIDTH-1:0]      RST_TIMEOUT       = 32'd1000000;
    localparam logic [DEBOUNCE_WIDTH-1:0] RST_DEBOUNCE      = 16'd200;
    localparam logic [CFG_WIDTH-1:0]      RST_MIN_PERIOD    = 32'd6000;
    localparam logic [CFG_WIDTH-1:0]      RST_MAX_PERIOD    = 32'd200000;

    typedef struct packed {
        logic [TOOTH_WIDTH-1:0]    teeth_per_rev;
        logic [CFG_WIDTH-1:0]      timeout_us;
        logic [DEBOUNCE_WIDTH-1:0] debounce_us;
        logic [CFG_WIDTH-1:0]      min_rev_period_us;
        logic [CFG_WIDTH-1:0]      max_rev_period_us;
    } cfg_t;

    typedef struct packed {
        logic [RPM_WIDTH-1:0] rpm_value;
        logic                 timed_out;
        logic                 edge_ignored;
        logic                 rev_complete;
        logic                 rpm_updated;
    } result_t;

endpackage

>>> sv/ctrm_if.sv
// valid/ready channel interfaces for edge words and result words
interface ctrm_in_if #(
    parameter int TIME_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [TIME_WIDTH-1:0] edge_time_us;

    modport source (output valid, output edge_time_us, input ready);
    modport sink   (input valid, input edge_time_us, output ready);
endinterface

interface ctrm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] rpm_value;
    logic        timed_out;
    logic        edge_ignored;
    logic        rev_complete;
    logic        rpm_updated;

    modport source (output valid, output rpm_value, output timed_out, output edge_ignored,
                    output rev_complete, output rpm_updated, input ready);
    modport sink   (input valid, input rpm_value, input timed_out, input edge_ignored,
                    input rev_complete, input rpm_updated, output ready);
endinterface

>>> sv/ctrm_sub.sv
// shared subtractor with borrow used for differences, compares and divide steps
module ctrm_sub #(
    parameter int WIDTH = 33
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] diff,
    output logic             borrow
);

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

>>> sv/ctrm_core.sv
// edge sequencer, state registers and serial divider around the shared subtractor
`include "crank_tooth_rpm_meter_macros.svh"

module ctrm_core #(
    parameter int TIME_WIDTH = ctrm_pkg::TIME_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [TIME_WIDTH-1:0]   edge_time,
    input  ctrm_pkg::cfg_t          cfg,
    output logic                    idle,
    output logic                    res_valid,
    input  logic                    res_take,
    output ctrm_pkg::result_t       result
);
    import ctrm_pkg::*;

    localparam int AW = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;
    localparam int UW = AW + 1;
    localparam logic [DIVIDEND_WIDTH-1:0] DIVIDEND = DIVIDEND_WIDTH'(US_PER_MINUTE);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_GAP  = 10'b0000000010,
        S_TO   = 10'b0000000100,
        S_DB   = 10'b0000001000,
        S_PER  = 10'b0000010000,
        S_MIN  = 10'b0000100000,
        S_MAX  = 10'b0001000000,
        S_DIV  = 10'b0010000000,
        S_SAT  = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [TIME_WIDTH-1:0]     last_edge_reg, last_edge_next;
    logic [TIME_WIDTH-1:0]     last_rev_reg, last_rev_next;
    logic [TOOTH_WIDTH-1:0]    tooth_reg, tooth_next;
    logic [RPM_WIDTH-1:0]      rpm_reg, rpm_next;
    logic [TIME_WIDTH-1:0]     now_reg, now_next;
    logic [TIME_WIDTH-1:0]     opnd_reg, opnd_next;
    logic [TIME_WIDTH-1:0]     rem_reg, rem_next;
    logic [DIVIDEND_WIDTH-1:0] quo_reg, quo_next;
    logic [CNT_WIDTH-1:0]      cnt_reg, cnt_next;
    logic                      to_reg, to_next;
    logic                      ign_reg, ign_next;
    logic                      closed_reg, closed_next;
    logic                      upd_reg, upd_next;

    logic [UW-1:0]             op_a, op_b, diff;
    logic                      borrow;
    logic [TIME_WIDTH:0]       shifted;
    logic [TOOTH_WIDTH-1:0]    tooth_inc;

    ctrm_sub #(.WIDTH(UW)) u_sub (
        .a      (op_a),
        .b      (op_b),
        .diff   (diff),
        .borrow (borrow)
    );

    assign shifted   = {rem_reg, DIVIDEND[cnt_reg]};
    assign tooth_inc = tooth_reg + TOOTH_WIDTH'(1);

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_GAP:
            begin
                op_a = UW'(now_reg);
                op_b = UW'(last_edge_reg);
            end
            S_TO:
            begin
                op_a = UW'(cfg.timeout_us);
                op_b = UW'(opnd_reg);
            end
            S_DB:
            begin
                op_a = UW'(opnd_reg);
                op_b = UW'(cfg.debounce_us);
            end
            S_PER:
            begin
                op_a = UW'(now_reg);
                op_b = UW'(last_rev_reg);
            end
            S_MIN:
            begin
                op_a = UW'(cfg.min_rev_period_us);
                op_b = UW'(opnd_reg);
            end
            S_MAX:
            begin
                op_a = UW'(opnd_reg);
                op_b = UW'(cfg.max_rev_period_us);
            end
            S_DIV:
            begin
                op_a = UW'(shifted);
                op_b = UW'(opnd_reg);
            end
            S_SAT:
            begin
                op_a = UW'(RPM_CEILING);
                op_b = UW'(quo_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        last_edge_next = last_edge_reg;
        last_rev_next  = last_rev_reg;
        tooth_next     = tooth_reg;
        rpm_next       = rpm_reg;
        now_next       = now_reg;
        opnd_next      = opnd_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        to_next        = to_reg;
        ign_next       = ign_reg;
        closed_next    = closed_reg;
        upd_next       = upd_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    now_next    = edge_time;
                    to_next     = 1'b0;
                    ign_next    = 1'b0;
                    closed_next = 1'b0;
                    upd_next    = 1'b0;
                    state_next  = S_GAP;
                end
            end
            S_GAP:
            begin
                opnd_next  = diff[TIME_WIDTH-1:0];
                state_next = S_TO;
            end
            S_TO:
            begin
                if (borrow)
                begin
                    to_next        = 1'b1;
                    rpm_next       = '0;
                    tooth_next     = '0;
                    last_edge_next = now_reg;
                    last_rev_next  = now_reg;
                    state_next     = S_FIN;
                end
                else
                begin
                    state_next = S_DB;
                end
            end
            S_DB:
            begin
                if (borrow)
                begin
                    ign_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    last_edge_next = now_reg;
                    if (tooth_inc >= cfg.teeth_per_rev)
                    begin
                        closed_next = 1'b1;
                        tooth_next  = '0;
                        state_next  = S_PER;
                    end
                    else
                    begin
                        tooth_next = tooth_inc;
                        state_next = S_FIN;
                    end
                end
            end
            S_PER:
            begin
                opnd_next     = diff[TIME_WIDTH-1:0];
                last_rev_next = now_reg;
                state_next    = S_MIN;
            end
            S_MIN:
            begin
                state_next = borrow ? S_MAX : S_FIN;
            end
            S_MAX:
            begin
                if (borrow)
                begin
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = CNT_WIDTH'(DIVIDEND_WIDTH - 1);
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                rem_next = borrow ? shifted[TIME_WIDTH-1:0] : diff[TIME_WIDTH-1:0];
                quo_next = {quo_reg[DIVIDEND_WIDTH-2:0], ~borrow};
                if (cnt_reg == '0)
                begin
                    state_next = S_SAT;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_WIDTH'(1);
                end
            end
            S_SAT:
            begin
                rpm_next   = borrow ? RPM_WIDTH'(RPM_CEILING) : quo_reg[RPM_WIDTH-1:0];
                upd_next   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_edge_reg <= '0;
            last_rev_reg  <= '0;
            tooth_reg     <= '0;
            rpm_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            last_edge_reg <= last_edge_next;
            last_rev_reg  <= last_rev_next;
            tooth_reg     <= tooth_next;
            rpm_reg       <= rpm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg    <= now_next;
        opnd_reg   <= opnd_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        to_reg     <= to_next;
        ign_reg    <= ign_next;
        closed_reg <= closed_next;
        upd_reg    <= upd_next;
    end

    assign idle                = (state_reg == S_IDLE);
    assign res_valid           = (state_reg == S_FIN);
    assign result.rpm_value    = rpm_reg;
    assign result.timed_out    = to_reg;
    assign result.edge_ignored = ign_reg;
    assign result.rev_complete = closed_reg;
    assign result.rpm_updated  = upd_reg;

    `CTRM_ASSERT_NEXT(a_start_leaves_idle, start && idle, state_reg == S_GAP)
    `CTRM_ASSERT_IMP(a_rem_below_divisor, state_reg == S_DIV, rem_reg < opnd_reg)
    `CTRM_ASSERT_IMP(a_rpm_ceiling, 1'b1, rpm_reg <= RPM_WIDTH'(RPM_CEILING))
    `CTRM_ASSERT_IMP(a_update_needs_rev, res_valid && upd_reg, closed_reg && !to_reg && !ign_reg)
    `CTRM_ASSERT_NEXT(a_result_holds, res_valid && !res_take, res_valid && $stable(result))

endmodule

>>> sv/crank_tooth_rpm_meter.sv
// top level of the crank tooth rpm meter: config registers, core and output register
//
// One result word per accepted edge word. The edge is taken when the core is
// idle; a timed-out edge has its result word offered after the gap and timeout
// states, a debounced edge or a plain tooth after the debounce state too, a
// closed revolution outside the sanity window after the period and window
// states, and an rpm update after the restoring divider runs 26 quotient bits,
// one per cycle, through the one shared subtractor for every difference and time
// compare. The result moves into the output register once it is empty or read,
// so the next edge is taken in the following cycle even while that word waits.
module crank_tooth_rpm_meter #(
    parameter int TIME_WIDTH = ctrm_pkg::TIME_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ctrm_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [ctrm_pkg::CFG_WIDTH-1:0]     cfg_wdata,
    ctrm_in_if.sink                            edge_in,
    ctrm_out_if.source                         rpm_out
);
    import ctrm_pkg::*;

    cfg_t    cfg_reg;
    result_t core_result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    core_idle;
    logic    res_valid;
    logic    res_take;
    logic    start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.teeth_per_rev     <= RST_TEETH_PER_REV;
            cfg_reg.timeout_us        <= RST_TIMEOUT;
            cfg_reg.debounce_us       <= RST_DEBOUNCE;
            cfg_reg.min_rev_period_us <= RST_MIN_PERIOD;
            cfg_reg.max_rev_period_us <= RST_MAX_PERIOD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEETH_PER_REV: cfg_reg.teeth_per_rev     <= cfg_wdata[TOOTH_WIDTH-1:0];
                CFG_TIMEOUT:       cfg_reg.timeout_us        <= cfg_wdata;
                CFG_DEBOUNCE:      cfg_reg.debounce_us       <= cfg_wdata[DEBOUNCE_WIDTH-1:0];
                CFG_MIN_PERIOD:    cfg_reg.min_rev_period_us <= cfg_wdata;
                CFG_MAX_PERIOD:    cfg_reg.max_rev_period_us <= cfg_wdata;
                default:           cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    assign edge_in.ready = core_idle;
    assign start         = edge_in.valid && core_idle;
    assign res_take      = res_valid && (!out_valid_reg || rpm_out.ready);

    ctrm_core #(.TIME_WIDTH(TIME_WIDTH)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .edge_time (edge_in.edge_time_us),
        .cfg       (cfg_reg),
        .idle      (core_idle),
        .res_valid (res_valid),
        .res_take  (res_take),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rpm_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= core_result;
        end
    end

    assign rpm_out.valid        = out_valid_reg;
    assign rpm_out.rpm_value    = out_reg.rpm_value;
    assign rpm_out.timed_out    = out_reg.timed_out;
    assign rpm_out.edge_ignored = out_reg.edge_ignored;
    assign rpm_out.rev_complete = out_reg.rev_complete;
    assign rpm_out.rpm_updated  = out_reg.rpm_updated;

endmodule

>>> test/ctrm_checker.sv
`timescale 1ns / 1ps
// checker that predicts the rpm meter result words and compares them as they leave
module ctrm_checker #(
    parameter int TIME_WIDTH = ctrm_pkg::TIME_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ctrm_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [ctrm_pkg::CFG_WIDTH-1:0]     cfg_wdata,
    ctrm_in_if                                 edge_mon,
    ctrm_out_if                                rpm_mon,
    output int                                 mismatch_count,
    output int                                 words_pending
);
    import ctrm_pkg::*;

    localparam logic [31:0] MINUTE_US = US_PER_MINUTE;

    cfg_t                  meter_cfg;
    logic [TIME_WIDTH-1:0] last_edge_mark;
    logic [TIME_WIDTH-1:0] last_rev_mark;
    logic [TOOTH_WIDTH-1:0] teeth_seen;
    logic [RPM_WIDTH-1:0]  rpm_now;
    result_t               expected_words[$];

    function automatic result_t predict_edge_result(input logic [TIME_WIDTH-1:0] now);
        logic [TIME_WIDTH-1:0] gap;
        logic [TIME_WIDTH-1:0] period;
        logic [31:0]           quotient;
        result_t               r;
        r = '0;
        gap = now - last_edge_mark;
        if (gap > meter_cfg.timeout_us)
        begin
            r.timed_out = 1'b1;
            rpm_now = '0;
            teeth_seen = '0;
            last_edge_mark = now;
            last_rev_mark = now;
        end
        else if (gap < meter_cfg.debounce_us)
        begin
            r.edge_ignored = 1'b1;
        end
        else
        begin
            last_edge_mark = now;
            teeth_seen = teeth_seen + 1'b1;
            if (teeth_seen >= meter_cfg.teeth_per_rev)
            begin
                period = now - last_rev_mark;
                r.rev_complete = 1'b1;
                last_rev_mark = now;
                teeth_seen = '0;
                if (period > meter_cfg.min_rev_period_us && period < meter_cfg.max_rev_period_us)
                begin
                    quotient = MINUTE_US / period;
                    if (quotient > RPM_CEILING)
                        rpm_now = RPM_WIDTH'(RPM_CEILING);
                    else
                        rpm_now = quotient[RPM_WIDTH-1:0];
                    r.rpm_updated = 1'b1;
                end
            end
        end
        r.rpm_value = rpm_now;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_w;
        if (!rst_n)
        begin
            meter_cfg.teeth_per_rev     = RST_TEETH_PER_REV;
            meter_cfg.timeout_us        = RST_TIMEOUT;
            meter_cfg.debounce_us       = RST_DEBOUNCE;
            meter_cfg.min_rev_period_us = RST_MIN_PERIOD;
            meter_cfg.max_rev_period_us = RST_MAX_PERIOD;
            last_edge_mark = '0;
            last_rev_mark  = '0;
            teeth_seen     = '0;
            rpm_now        = '0;
            expected_words.delete();
            mismatch_count = 0;
            words_pending <= 0;
        end
        else
        begin
            if (rpm_mon.valid && rpm_mon.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: expected no result word, actual rpm %0d to %b ig %b rev %b upd %b",
                             $time, rpm_mon.rpm_value, rpm_mon.timed_out,
                             rpm_mon.edge_ignored, rpm_mon.rev_complete, rpm_mon.rpm_updated);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (rpm_mon.rpm_value !== exp_w.rpm_value
                        || rpm_mon.timed_out !== exp_w.timed_out
                        || rpm_mon.edge_ignored !== exp_w.edge_ignored
                        || rpm_mon.rev_complete !== exp_w.rev_complete
                        || rpm_mon.rpm_updated !== exp_w.rpm_updated)
                    begin
                        mismatch_count++;
                        $display({"%0t: expected rpm %0d to %b ig %b rev %b upd %b, ",
                                  "actual rpm %0d to %b ig %b rev %b upd %b"}, $time,
                                 exp_w.rpm_value, exp_w.timed_out, exp_w.edge_ignored,
                                 exp_w.rev_complete, exp_w.rpm_updated,
                                 rpm_mon.rpm_value, rpm_mon.timed_out,
                                 rpm_mon.edge_ignored, rpm_mon.rev_complete,
                                 rpm_mon.rpm_updated);
                    end
                end
            end
            if (edge_mon.valid && edge_mon.ready)
                expected_words.push_back(predict_edge_result(edge_mon.edge_time_us));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TEETH_PER_REV: meter_cfg.teeth_per_rev     = cfg_wdata[TOOTH_WIDTH-1:0];
                    CFG_TIMEOUT:       meter_cfg.timeout_us        = cfg_wdata;
                    CFG_DEBOUNCE:      meter_cfg.debounce_us       = cfg_wdata[DEBOUNCE_WIDTH-1:0];
                    CFG_MIN_PERIOD:    meter_cfg.min_rev_period_us = cfg_wdata;
                    CFG_MAX_PERIOD:    meter_cfg.max_rev_period_us = cfg_wdata;
                    default: ;
                endcase
            end
            words_pending <= expected_words.size();
        end
    end

endmodule

>>> test/tb_crank_tooth_rpm_meter.sv
`timescale 1ns / 1ps
// top of the rpm meter testbench: clock, reset, edge and config stimulus, verdict
module tb_crank_tooth_rpm_meter;
    import ctrm_pkg::*;

    localparam int TAIL_CYCLES      = 40;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS     = 1700;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_FIRST = CFG_MAX_PERIOD + 1'b1;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]     cfg_wdata;
    int                       mismatch_count;
    int                       words_pending;

    logic [31:0] now_us;
    logic [31:0] cur_timeout;
    logic [15:0] cur_debounce;
    bit          offering;
    bit          hold_req;
    bit          steady;
    int          burst_left;
    int          items_sent;

    ctrm_in_if #(.TIME_WIDTH(TIME_WIDTH_DEF)) edge_in ();
    ctrm_out_if rpm_out ();

    crank_tooth_rpm_meter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .edge_in   (edge_in),
        .rpm_out   (rpm_out)
    );

    ctrm_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .edge_mon       (edge_in),
        .rpm_mon        (rpm_out),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // result receiver: own stall pattern plus one long hold-off on request
    initial
    begin
        int mode;
        int span;
        int cyc;
        rpm_out.ready = 1'b0;
        cyc = 0;
        forever
        begin
            if (hold_req)
            begin
                repeat (LONG_HOLD_CYCLES)
                begin
                    @(posedge clk);
                    rpm_out.ready <= 1'b0;
                end
                hold_req = 1'b0;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(1, 60);
                repeat (span)
                begin
                    @(posedge clk);
                    cyc++;
                    case (mode)
                        0: rpm_out.ready <= 1'b1;
                        1: rpm_out.ready <= 1'($urandom_range(0, 1));
                        2: rpm_out.ready <= ($urandom_range(0, 7) == 0);
                        default: rpm_out.ready <= (cyc % 3 != 0);
                    endcase
                end
            end
        end
    end

    task automatic send_edge(input logic [31:0] t);
        edge_in.valid <= 1'b1;
        edge_in.edge_time_us <= t;
        offering = 1'b1;
        @(posedge clk);
        while (!edge_in.ready)
            @(posedge clk);
        items_sent++;
        if (!steady)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                edge_in.valid <= 1'b0;
                offering = 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    task automatic wait_idle();
        if (offering)
        begin
            edge_in.valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] teeth_w, input logic [31:0] timeout_w,
                              input logic [31:0] debounce_w, input logic [31:0] min_w,
                              input logic [31:0] max_w);
        write_reg(CFG_TEETH_PER_REV, teeth_w);
        write_reg(CFG_TIMEOUT, timeout_w);
        write_reg(CFG_DEBOUNCE, debounce_w);
        write_reg(CFG_MIN_PERIOD, min_w);
        write_reg(CFG_MAX_PERIOD, max_w);
        // unused index, must leave every register alone
        write_reg(CFG_SPARE_FIRST + CFG_IDX_WIDTH'($urandom_range(0, 2)), $urandom);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_timeout = timeout_w;
        cur_debounce = debounce_w[15:0];
    endtask

    task automatic run_phase(input int count, input logic [31:0] g_lo, input logic [31:0] g_hi);
        logic [31:0] gap;
        int          pick;
        steady = ($urandom_range(0, 3) == 0);
        burst_left = 0;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                gap = $urandom_range(g_lo, g_hi);
            else if (pick < 78)
                gap = $urandom_range(0, cur_debounce);
            else if (pick < 86)
            begin
                case ($urandom_range(0, 3))
                    0: gap = {16'd0, cur_debounce} - 1'b1;
                    1: gap = {16'd0, cur_debounce};
                    2: gap = cur_timeout;
                    default: gap = cur_timeout + 1'b1;
                endcase
            end
            else if (pick < 92)
                gap = cur_timeout + $urandom_range(1, 100000);
            else
                gap = $urandom;
            now_us = now_us + gap;
            send_edge(now_us);
        end
        wait_idle();
    endtask

    initial
    begin
        logic [5:0]  teeth;
        logic [31:0] tmo;
        logic [15:0] deb;
        logic [31:0] mn;
        logic [31:0] mx;
        longint      teff;
        longint      lo;
        longint      hi;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        edge_in.valid = 1'b0;
        edge_in.edge_time_us = '0;
        offering = 1'b0;
        hold_req = 1'b0;
        steady = 1'b0;
        burst_left = 0;
        items_sent = 0;
        cur_timeout = RST_TIMEOUT;
        cur_debounce = RST_DEBOUNCE;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: first edge against zero, debounce, a good revolution,
        // timeouts, timestamp wrap, and a revolution too slow for the window
        send_edge(32'd0);
        send_edge(32'd100);
        send_edge(32'd200);
        for (int k = 1; k <= 10; k++)
            send_edge(32'd200 + 32'd1000 * k);
        send_edge(32'd10200 + 32'd1000001);
        send_edge(32'hFFFF_FFFF);
        now_us = 32'h0000_0100;
        send_edge(now_us);
        repeat (10)
        begin
            now_us = now_us + 32'd25000;
            send_edge(now_us);
        end
        wait_idle();

        // one tooth per rev, widest window: saturation and zero period
        set_config(32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF);
        run_phase(80, 32'd0, 32'd2000);

        // most teeth, widest debounce, junk in upper write bits; long receiver hold
        set_config(32'hFFFF_FFFF, 32'd5000000, 32'hFFFF_FFFF, 32'd1000, 32'hFFFF_FFFF);
        hold_req = 1'b1;
        run_phase(150, 32'd65535, 32'd79000);

        // zero teeth with a count left over, a one-microsecond timeout, tiny window
        set_config(32'd0, 32'd1, 32'd0, 32'd0, 32'd5);
        run_phase(60, 32'd0, 32'd1);

        // empty window
        set_config(32'd4, 32'd1000000, 32'd200, 32'd100000, 32'd100000);
        run_phase(80, 32'd20000, 32'd30000);

        set_config(32'hFFFF_FFC8, 32'd1000000, 32'hABCD_0010, 32'd6000, 32'd200000);
        run_phase(80, 32'd750, 32'd25000);

        while (items_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0: teeth = 6'd0;
                1: teeth = 6'd63;
                2: teeth = 6'd1;
                default: teeth = 6'($urandom_range(2, 62));
            endcase
            case ($urandom_range(0, 7))
                0: tmo = 32'hFFFF_FFFF;
                1: tmo = 32'd1;
                default: tmo = $urandom_range(50000, 3000000);
            endcase
            case ($urandom_range(0, 5))
                0: deb = 16'd0;
                1: deb = 16'hFFFF;
                default: deb = 16'($urandom_range(0, 3000));
            endcase
            case ($urandom_range(0, 7))
                0: mn = 32'd0;
                1: mn = 32'd1000;
                2: mn = 32'hFFFF_FFFF;
                default: mn = $urandom_range(1000, 40000);
            endcase
            case ($urandom_range(0, 7))
                0: mx = 32'hFFFF_FFFF;
                1: mx = 32'd1;
                default: mx = mn + $urandom_range(1, 400000);
            endcase
            teff = (teeth == 6'd0) ? longint'(1) : longint'(teeth);
            lo = longint'(mn) / teff;
            hi = longint'(mx) / teff;
            if (lo < longint'(deb))
                lo = longint'(deb);
            if (hi > longint'(tmo))
                hi = longint'(tmo);
            if (lo > longint'(32'hFFFF_F000))
                lo = longint'(32'hFFFF_F000);
            if (hi <= lo)
                hi = lo + longint'(2000);
            set_config(($urandom << 6) | teeth, tmo, ($urandom << 16) | deb, mn, mx);
            run_phase(150, lo[31:0], hi[31:0]);
        end

        if (mismatch_count == 0 && words_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/ctrm_pkg.sv
sv/ctrm_if.sv
sv/ctrm_sub.sv
sv/ctrm_core.sv
sv/crank_tooth_rpm_meter.sv
test/ctrm_checker.sv
test/tb_crank_tooth_rpm_meter.sv
